// File: hdl/filtered_pid_position_controller_unit_defines.svh
// Assertion shorthands shared by the controller files.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef FILTERED_PID_POSITION_CONTROLLER_UNIT_DEFINES_SVH
`define FILTERED_PID_POSITION_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FPID_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FPID_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fpid_pkg.sv
package fpid_pkg;

  // Parameter defaults
  localparam int SUM_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;

  // Field and register widths
  localparam int REF_W        = 12;
  localparam int ANG_W        = 16;
  localparam int CODE_W       = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int PROP_W       = 24;
  localparam int INTEG_W      = 32;
  localparam int DERIV_GAIN_W = 24;
  localparam int SMOOTH_W     = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_SMOOTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_SMOOTH  = 3'd4;

  // Register reset values
  localparam logic [PROP_W-1:0]       PROP_GAIN_RST    = 24'd327680;
  localparam logic [INTEG_W-1:0]      INTEG_GAIN_RST   = 32'd42950;
  localparam logic [DERIV_GAIN_W-1:0] DERIV_GAIN_RST   = 24'd896000;
  localparam logic [SMOOTH_W-1:0]     DERIV_SMOOTH_RST = 16'd492;
  localparam logic [SMOOTH_W-1:0]     OUT_SMOOTH_RST   = 16'd3277;

  // Angle scales in Q.32 radians per code: 1/217.2465 and 6*3.1416/65535
  localparam int SCALE_W = 25;
  localparam logic [SCALE_W-1:0] REF_SCALE = 25'd19770018;
  localparam logic [SCALE_W-1:0] ANG_SCALE = 25'd1235346;
  localparam int ANGLE_FRAC = 32;

  // Output coding: (u + 12 V) * 2730
  localparam int FULL_VOLTS = 12;
  localparam int CODE_SCALE_W = 12;
  localparam logic [CODE_SCALE_W-1:0] CODE_SCALE = 12'd2730;
  localparam logic [CODE_W-1:0] CODE_MAX = 16'd65520;

  // Shared multiplier datapath
  localparam int GAIN_W    = 32;
  localparam int MAG_W     = 64;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = HALF_W + GAIN_W;
  localparam int ACC_W     = MAG_W + GAIN_W;
  localparam int TERM_W    = 48;
  localparam int LIM_SHIFT = 46;
  localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << LIM_SHIFT;
  localparam int DERIV_W   = 40;

  typedef enum logic [1:0] {
    SH_8,
    SH_16,
    SH_32
  } shift_sel_t;

  typedef struct packed {
    logic       start;
    shift_sel_t shift;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_rsp_t;

endpackage

// File: hdl/fpid_mul.sv
`include "filtered_pid_position_controller_unit_defines.svh"

// Sign-magnitude gain multiply: round(op * gain / 2^shift), ties away from
// zero, magnitude capped at TERM_LIM. Two 32x32 partial products.
module fpid_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fpid_pkg::mul_req_t                     req,
  input  logic signed [fpid_pkg::MAG_W-1:0]      operand,
  input  logic        [fpid_pkg::GAIN_W-1:0]     gain,
  output fpid_pkg::mul_rsp_t                     rsp,
  output logic signed [fpid_pkg::TERM_W-1:0]     result
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_LO,
    U_HI,
    U_ACC,
    U_FIN
  } ustate_t;

  localparam logic signed [fpid_pkg::TERM_W-1:0] LIM_S = fpid_pkg::TERM_LIM;

  ustate_t                          state_r;
  logic                             done_r;
  logic                             neg_r;
  fpid_pkg::shift_sel_t             shift_r;
  logic [fpid_pkg::MAG_W-1:0]       mag_r;
  logic [fpid_pkg::GAIN_W-1:0]      gain_r;
  logic [fpid_pkg::PROD_W-1:0]      p0_r;
  logic [fpid_pkg::PROD_W-1:0]      p1_r;
  logic [fpid_pkg::ACC_W-1:0]       acc_r;
  logic signed [fpid_pkg::TERM_W-1:0] result_r;

  logic [fpid_pkg::ACC_W-1:0]       rnd;
  logic [fpid_pkg::ACC_W-1:0]       shifted;
  logic [fpid_pkg::TERM_W-1:0]      mag_sat;
  logic signed [fpid_pkg::TERM_W-1:0] result_nxt;

  always_comb begin
    case (shift_r)
      fpid_pkg::SH_8:  rnd = fpid_pkg::ACC_W'(1) << 7;
      fpid_pkg::SH_16: rnd = fpid_pkg::ACC_W'(1) << 15;
      fpid_pkg::SH_32: rnd = fpid_pkg::ACC_W'(1) << 31;
      default:         rnd = '0;
    endcase
  end

  always_comb begin
    case (shift_r)
      fpid_pkg::SH_8:  shifted = acc_r >> 8;
      fpid_pkg::SH_16: shifted = acc_r >> 16;
      fpid_pkg::SH_32: shifted = acc_r >> 32;
      default:         shifted = acc_r;
    endcase
    if (shifted > fpid_pkg::ACC_W'(fpid_pkg::TERM_LIM)) begin
      mag_sat = fpid_pkg::TERM_LIM;
    end else begin
      mag_sat = shifted[fpid_pkg::TERM_W-1:0];
    end
    result_nxt = neg_r ? -$signed(mag_sat) : $signed(mag_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (req.start) begin
            state_r <= U_LO;
          end
        end
        U_LO:  state_r <= U_HI;
        U_HI:  state_r <= U_ACC;
        U_ACC: state_r <= U_FIN;
        U_FIN: begin
          state_r <= U_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  // Datapath: latch on start, then one step per cycle
  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          neg_r   <= operand[fpid_pkg::MAG_W-1];
          mag_r   <= operand[fpid_pkg::MAG_W-1] ? fpid_pkg::MAG_W'(-operand)
                                                : fpid_pkg::MAG_W'(operand);
          gain_r  <= gain;
          shift_r <= req.shift;
        end
      end
      U_LO:  p0_r <= mag_r[fpid_pkg::HALF_W-1:0] * gain_r;
      U_HI:  p1_r <= mag_r[fpid_pkg::MAG_W-1:fpid_pkg::HALF_W] * gain_r;
      U_ACC: acc_r <= fpid_pkg::ACC_W'(p0_r)
                    + (fpid_pkg::ACC_W'(p1_r) << fpid_pkg::HALF_W) + rnd;
      U_FIN: result_r <= result_nxt;
      default: ;
    endcase
  end

  assign rsp.busy = (state_r != U_IDLE);
  assign rsp.done = done_r;
  assign result   = result_r;

  `FPID_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "multiply done held longer than a cycle")
  `FPID_ASSERT_NEXT(a_start_busy, req.start && state_r == U_IDLE, rsp.busy, "start not taken")
  `FPID_ASSERT_NOW(a_result_lim, done_r, result_r <= LIM_S && result_r >= -LIM_S, "term out of range")

endmodule

// File: hdl/filtered_pid_position_controller_unit.sv
// Channel   Direction  Ports                                          Request
// --------  ---------  ---------------------------------------------  ----------------------
// in        input      in_valid, in_stall, in_position_ref,           one control sample
//                      in_measured_angle
// out       output     out_valid, out_stall, out_drive_code           one drive code
// cfg       input      cfg_wr_en, cfg_index, cfg_data                 one register write
//
// Steps per request: the error, the error sum, then passes through the shared
// multiplier for P, I and raw D and for the D filter, the sum of the terms with
// the output filter pass, and the output coding: five multiplier passes in all.
// Reset: synchronous, active low; clears the loop state and restores registers.
// in_stall is high from acceptance until the result sits in the output register.
// A stalled output holds the next result in the coding step until it drains.
`include "filtered_pid_position_controller_unit_defines.svh"

module filtered_pid_position_controller_unit #(
  parameter int SUM_WIDTH = fpid_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = fpid_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fpid_pkg::REF_W-1:0]         in_position_ref,
  input  logic [fpid_pkg::ANG_W-1:0]         in_measured_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fpid_pkg::CODE_W-1:0]        out_drive_code,
  input  logic                               cfg_wr_en,
  input  logic [fpid_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Error: signed, FRAC_BITS fraction bits, spans about +/-6*pi
  localparam int E_W    = FRAC_BITS + 8;
  // Output filter state: clamped to +/-12 V
  localparam int OUT_W  = FRAC_BITS + 8;
  localparam int DIFF_W = fpid_pkg::SCALE_W + fpid_pkg::ANG_W + 2;
  localparam int E_SHIFT = fpid_pkg::ANGLE_FRAC - FRAC_BITS;
  localparam int TW     = fpid_pkg::TERM_W;
  localparam int MW     = fpid_pkg::MAG_W;

  localparam logic signed [DIFF_W-1:0] E_HALF = DIFF_W'(1) << (E_SHIFT - 1);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX =
    {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN =
    {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [TW:0] D_HI =
    {{(TW-fpid_pkg::DERIV_W+2){1'b0}}, {(fpid_pkg::DERIV_W-1){1'b1}}};
  localparam logic signed [TW:0] D_LO =
    {{(TW-fpid_pkg::DERIV_W+2){1'b1}}, {(fpid_pkg::DERIV_W-1){1'b0}}};
  localparam logic signed [TW:0] FS_POS = (TW+1)'(fpid_pkg::FULL_VOLTS) << FRAC_BITS;
  localparam logic signed [TW:0] FS_NEG = -FS_POS;
  localparam logic signed [OUT_W-1:0] FS_OUT = OUT_W'(fpid_pkg::FULL_VOLTS) << FRAC_BITS;
  localparam int CODE_FULL_W = OUT_W + fpid_pkg::CODE_SCALE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SUM,
    ST_P,
    ST_I,
    ST_D,
    ST_A,
    ST_S,
    ST_B,
    ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [fpid_pkg::PROP_W-1:0]       prop_gain_r;
  logic [fpid_pkg::INTEG_W-1:0]      integral_gain_dt_r;
  logic [fpid_pkg::DERIV_GAIN_W-1:0] deriv_gain_per_dt_r;
  logic [fpid_pkg::SMOOTH_W-1:0]     deriv_smoothing_r;
  logic [fpid_pkg::SMOOTH_W-1:0]     output_smoothing_r;

  // Loop state
  logic signed [SUM_WIDTH-1:0]          error_sum_r;
  logic signed [E_W-1:0]                last_error_r;
  logic signed [fpid_pkg::DERIV_W-1:0]  deriv_filtered_r;
  logic signed [OUT_W-1:0]              output_filtered_r;

  // Per-request working registers
  logic [fpid_pkg::REF_W-1:0]  ref_r;
  logic [fpid_pkg::ANG_W-1:0]  ang_r;
  logic signed [E_W-1:0]       e_r;
  logic signed [TW-1:0]        ep_r;
  logic signed [TW-1:0]        ei_r;

  logic                        out_valid_r;
  logic [fpid_pkg::CODE_W-1:0] out_drive_code_r;

  // Shared multiplier hookup
  fpid_pkg::mul_req_t          mul_req;
  fpid_pkg::mul_rsp_t          mul_rsp;
  logic signed [MW-1:0]        mul_op;
  logic [fpid_pkg::GAIN_W-1:0] mul_gain;
  logic signed [TW-1:0]        mul_res;

  logic signed [DIFF_W-1:0]    diff;
  logic signed [DIFF_W-1:0]    diff_rnd;
  logic signed [E_W-1:0]       e_nxt;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] error_sum_nxt;
  logic signed [TW:0]          d_wide;
  logic signed [fpid_pkg::DERIV_W-1:0] deriv_nxt;
  logic signed [TW:0]          u_wide;
  logic signed [OUT_W-1:0]     output_nxt;
  logic [OUT_W-1:0]            u_off;
  logic [CODE_FULL_W-1:0]      code_full;
  logic                        out_free;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_drive_code = out_drive_code_r;
  assign out_free       = !out_valid_r || !out_stall;

  // Error: scale both angles to Q.32, subtract, round half up to FRAC_BITS
  always_comb begin
    diff = $signed(DIFF_W'(ref_r) * DIFF_W'(fpid_pkg::REF_SCALE))
         - $signed(DIFF_W'(ang_r) * DIFF_W'(fpid_pkg::ANG_SCALE));
    diff_rnd = diff + E_HALF;
    e_nxt = E_W'(diff_rnd >>> E_SHIFT);
  end

  // Saturating error sum
  always_comb begin
    sum_wide = (SUM_WIDTH+1)'(error_sum_r) + (SUM_WIDTH+1)'(e_r);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      error_sum_nxt = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // Derivative filter update with 40-bit saturation
  always_comb begin
    d_wide = (TW+1)'(deriv_filtered_r) + (TW+1)'(mul_res);
    if (d_wide > D_HI) begin
      deriv_nxt = fpid_pkg::DERIV_W'(D_HI);
    end else if (d_wide < D_LO) begin
      deriv_nxt = fpid_pkg::DERIV_W'(D_LO);
    end else begin
      deriv_nxt = fpid_pkg::DERIV_W'(d_wide);
    end
  end

  // Output filter update, clamp to +/-12 V
  always_comb begin
    u_wide = (TW+1)'(output_filtered_r) + (TW+1)'(mul_res);
    if (u_wide > FS_POS) begin
      output_nxt = OUT_W'(FS_POS);
    end else if (u_wide < FS_NEG) begin
      output_nxt = OUT_W'(FS_NEG);
    end else begin
      output_nxt = OUT_W'(u_wide);
    end
  end

  // Offset-binary drive code
  always_comb begin
    u_off     = OUT_W'(output_filtered_r + FS_OUT);
    code_full = CODE_FULL_W'(u_off) * CODE_FULL_W'(fpid_pkg::CODE_SCALE);
  end

  // Multiplier request per step; the I, raw D and D filter passes start in the cycle the previous pass signals done
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.shift = fpid_pkg::SH_16;
    mul_op        = '0;
    mul_gain      = '0;
    case (state_r)
      ST_SUM: begin
        mul_req.start = 1'b1;
        mul_op        = MW'(e_r);
        mul_gain      = fpid_pkg::GAIN_W'(prop_gain_r);
      end
      ST_P: begin
        mul_req.start = mul_rsp.done;
        mul_req.shift = fpid_pkg::SH_32;
        mul_op        = MW'(error_sum_r);
        mul_gain      = integral_gain_dt_r;
      end
      ST_I: begin
        mul_req.start = mul_rsp.done;
        mul_req.shift = fpid_pkg::SH_8;
        mul_op        = MW'(e_r) - MW'(last_error_r);
        mul_gain      = fpid_pkg::GAIN_W'(deriv_gain_per_dt_r);
      end
      ST_D: begin
        mul_req.start = mul_rsp.done;
        mul_op        = MW'(mul_res) - MW'(deriv_filtered_r);
        mul_gain      = fpid_pkg::GAIN_W'(deriv_smoothing_r);
      end
      ST_S: begin
        mul_req.start = 1'b1;
        mul_op        = MW'(ep_r) + MW'(ei_r) + MW'(deriv_filtered_r)
                      - MW'(output_filtered_r);
        mul_gain      = fpid_pkg::GAIN_W'(output_smoothing_r);
      end
      default: ;
    endcase
  end

  fpid_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .operand (mul_op),
    .gain    (mul_gain),
    .rsp     (mul_rsp),
    .result  (mul_res)
  );

  // Configuration writes; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r         <= fpid_pkg::PROP_GAIN_RST;
      integral_gain_dt_r  <= fpid_pkg::INTEG_GAIN_RST;
      deriv_gain_per_dt_r <= fpid_pkg::DERIV_GAIN_RST;
      deriv_smoothing_r   <= fpid_pkg::DERIV_SMOOTH_RST;
      output_smoothing_r  <= fpid_pkg::OUT_SMOOTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fpid_pkg::REG_PROP_GAIN:    prop_gain_r <= cfg_data[fpid_pkg::PROP_W-1:0];
        fpid_pkg::REG_INTEG_GAIN:   integral_gain_dt_r <= cfg_data[fpid_pkg::INTEG_W-1:0];
        fpid_pkg::REG_DERIV_GAIN:   deriv_gain_per_dt_r <= cfg_data[fpid_pkg::DERIV_GAIN_W-1:0];
        fpid_pkg::REG_DERIV_SMOOTH: deriv_smoothing_r <= cfg_data[fpid_pkg::SMOOTH_W-1:0];
        fpid_pkg::REG_OUT_SMOOTH:   output_smoothing_r <= cfg_data[fpid_pkg::SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, loop state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      out_valid_r       <= 1'b0;
      error_sum_r       <= '0;
      last_error_r      <= '0;
      deriv_filtered_r  <= '0;
      output_filtered_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_ERR;
          end
        end
        ST_ERR: state_r <= ST_SUM;
        ST_SUM: begin
          error_sum_r <= error_sum_nxt;
          state_r     <= ST_P;
        end
        ST_P: begin
          if (mul_rsp.done) begin
            state_r <= ST_I;
          end
        end
        ST_I: begin
          if (mul_rsp.done) begin
            state_r <= ST_D;
          end
        end
        ST_D: begin
          if (mul_rsp.done) begin
            state_r <= ST_A;
          end
        end
        ST_A: begin
          if (mul_rsp.done) begin
            deriv_filtered_r <= deriv_nxt;
            last_error_r     <= e_r;
            state_r          <= ST_S;
          end
        end
        ST_S: state_r <= ST_B;
        ST_B: begin
          if (mul_rsp.done) begin
            output_filtered_r <= output_nxt;
            state_r           <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold here until the output register can take the code
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_drive_code_r <= code_full[FRAC_BITS +: fpid_pkg::CODE_W];
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Per-request payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ref_r <= in_position_ref;
      ang_r <= in_measured_angle;
    end
    if (state_r == ST_ERR) begin
      e_r <= e_nxt;
    end
    if (state_r == ST_P && mul_rsp.done) begin
      ep_r <= mul_res;
    end
    if (state_r == ST_I && mul_rsp.done) begin
      ei_r <= mul_res;
    end
  end

  `FPID_ASSERT_NOW(a_ready_unit_idle, !in_stall, !mul_rsp.busy, "ready while multiplier busy")
  `FPID_ASSERT_NOW(a_start_unit_idle, mul_req.start, !mul_rsp.busy, "multiply started while busy")
  `FPID_ASSERT_NOW(a_done_in_wait, mul_rsp.done, state_r == ST_P || state_r == ST_I || state_r == ST_D || state_r == ST_A || state_r == ST_B, "multiply result in wrong step")
  `FPID_ASSERT_NOW(a_code_range, out_valid, out_drive_code <= fpid_pkg::CODE_MAX, "drive code above full scale")

endmodule
